// ----- rtl/nppc_pkg.sv -----
// Package for the parity and prime classifier.
// Holds widths, the controller state type and the command and status structs.
// Used by nppc_ctrl, nppc_dp and number_parity_prime_classifier.
package nppc_pkg;

  localparam int VALUE_BITS = 16;
  localparam int DIV_BITS   = VALUE_BITS / 2 + 2;
  localparam int SQ_BITS    = VALUE_BITS + 2;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);
  localparam logic [DIV_BITS-1:0] DIV_FIRST = DIV_BITS'(3);
  localparam logic [SQ_BITS-1:0]  SQ_FIRST  = SQ_BITS'(9);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic next_div;
    logic finish;
    logic prime;
  } cmd_t;

  typedef struct packed {
    logic below_two;
    logic is_two;
    logic even;
    logic sq_over;
    logic div_last;
    logic rem_zero;
  } status_t;

endpackage

// ----- rtl/nppc_ctrl.sv -----
// Controller state machine for the parity and prime classifier.
// Sequences trial divisors and division steps; depends on nppc_pkg.
module nppc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  nppc_pkg::status_t status,
  output nppc_pkg::cmd_t    cmd
);
  import nppc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.below_two || status.is_two || status.even) begin
          cmd.finish = 1'b1;
          cmd.prime  = status.is_two;
          state_nxt  = ST_IDLE;
        end else if (status.sq_over) begin
          cmd.finish = 1'b1;
          cmd.prime  = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.rem_zero) begin
          cmd.finish = 1'b1;
          cmd.prime  = 1'b0;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/nppc_dp.sv -----
// Datapath for the parity and prime classifier.
// Holds the word, the trial divisor, its square and a bit-serial remainder unit.
// Depends on nppc_pkg.
module nppc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [nppc_pkg::VALUE_BITS-1:0] in_value,
  input  nppc_pkg::cmd_t                  cmd,
  output nppc_pkg::status_t               status,
  output logic                           out_valid,
  output logic                           out_is_even,
  output logic                           out_is_odd,
  output logic                           out_is_prime
);
  import nppc_pkg::*;

  logic [VALUE_BITS-1:0] n_r;
  logic [VALUE_BITS-1:0] sh_r;
  logic [DIV_BITS-1:0]   d_r;
  logic [SQ_BITS-1:0]    sq_r;
  logic [DIV_BITS-1:0]   rem_r;
  logic [DIV_BITS-1:0]   rem_nxt;
  logic [DIV_BITS:0]     trial;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  valid_r;
  logic                  even_r;
  logic                  odd_r;
  logic                  prime_r;

  assign trial = {rem_r, sh_r[VALUE_BITS-1]};

  always_comb begin
    if (trial >= {1'b0, d_r}) begin
      rem_nxt = DIV_BITS'(trial - {1'b0, d_r});
    end else begin
      rem_nxt = trial[DIV_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= in_value;
      d_r  <= DIV_FIRST;
      sq_r <= SQ_FIRST;
    end else if (cmd.next_div) begin
      d_r  <= d_r + DIV_BITS'(2);
      sq_r <= sq_r + SQ_BITS'({d_r, 2'b00}) + SQ_BITS'(4);
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      sh_r  <= n_r;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[VALUE_BITS-2:0], 1'b0};
      cnt_r <= cnt_r + CNT_BITS'(1);
    end
    if (cmd.finish) begin
      even_r  <= ~n_r[0];
      odd_r   <= n_r[0];
      prime_r <= cmd.prime;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
    end
  end

  assign status.below_two = (n_r < VALUE_BITS'(2));
  assign status.is_two    = (n_r == VALUE_BITS'(2));
  assign status.even      = ~n_r[0];
  assign status.sq_over   = (sq_r > SQ_BITS'(n_r));
  assign status.div_last  = (cnt_r == CNT_LAST);
  assign status.rem_zero  = (rem_r == '0);

  assign out_valid    = valid_r;
  assign out_is_even  = even_r;
  assign out_is_odd   = odd_r;
  assign out_is_prime = prime_r;

endmodule

// ----- rtl/number_parity_prime_classifier.sv -----
// Top level of the parity and prime classifier; instantiates nppc_ctrl and nppc_dp.
// Words 0, 1, 2 and even words are classified by the check alone; an odd word is divided
// by each odd trial divisor d with d*d <= word, stopping early when a divisor is found.
// One word at a time: the next start is taken in the cycle the result strobes.
// Reset is synchronous, active low, and clears the state machine and the strobe.
// The result is on the out_ ports for one cycle and the receiver cannot stall.
module number_parity_prime_classifier (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [nppc_pkg::VALUE_BITS-1:0] in_value,
  output logic                           out_valid,
  output logic                           out_is_even,
  output logic                           out_is_odd,
  output logic                           out_is_prime
);
  import nppc_pkg::*;

  cmd_t    cmd;
  status_t status;

  nppc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  nppc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_value),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_is_even  (out_is_even),
    .out_is_odd   (out_is_odd),
    .out_is_prime (out_is_prime)
  );

  a_parity_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_is_even, out_is_odd}))
    else $error("parity flags not exclusive");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_even_prime: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_prime) |-> (out_is_odd || out_is_even))
    else $error("prime result without parity");

endmodule

// ----- sim/number_parity_prime_classifier_test.sv -----
// Testbench for number_parity_prime_classifier: drives words through the start/busy
// handshake and checks each parity and prime result against a trial-division predictor.
// Depends on nppc_pkg and the classifier RTL.
`timescale 1ns / 1ps

module number_parity_prime_classifier_test;

  localparam int VALUE_BITS = nppc_pkg::VALUE_BITS;
  localparam int SETTLE_CYCLES = 40;

  typedef logic [VALUE_BITS-1:0] word_t;

  typedef struct packed {
    logic is_even;
    logic is_odd;
    logic is_prime;
  } flags_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  word_t in_value = '0;
  logic  busy;
  logic  out_valid;
  logic  out_is_even;
  logic  out_is_odd;
  logic  out_is_prime;

  word_t  pending_words[$];
  flags_t expected_flags[$];
  int     sender_idle_pct = 37;
  int     mismatch_count = 0;
  logic   word_taken = 1'b0;

  number_parity_prime_classifier DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_is_even (out_is_even),
    .out_is_odd  (out_is_odd),
    .out_is_prime(out_is_prime)
  );

  always #2 clk = ~clk;

  function automatic flags_t classify_word(input word_t w);
    longint unsigned n;
    longint unsigned d;
    flags_t f;
    n = w;
    f.is_odd = w[0];
    f.is_even = ~w[0];
    if (n < 2) begin
      f.is_prime = 1'b0;
    end else if (n == 2) begin
      f.is_prime = 1'b1;
    end else if (!w[0]) begin
      f.is_prime = 1'b0;
    end else begin
      f.is_prime = 1'b1;
      for (d = 3; d * d <= n; d += 2) begin
        if (n % d == 0) f.is_prime = 1'b0;
      end
    end
    return f;
  endfunction

  function automatic word_t random_word();
    longint unsigned d;
    case ($urandom_range(0, 4))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 255));
      2: begin
        d = 2 * $urandom_range(1, 127) + 1;
        return word_t'(d * d + $urandom_range(0, 2) - 1);
      end
      3: return word_t'((2 * $urandom_range(1, 60) + 1) * (2 * $urandom_range(1, 500) + 1));
      default: return word_t'({VALUE_BITS{1'b1}} - $urandom_range(0, 40));
    endcase
  endfunction

  // Driver: holds a word until it is taken; between words it idles at random, with chance sender_idle_pct.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
      start <= 1'b1;
    end else if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
      start <= 1'b1;
      in_value <= pending_words[0];
    end else begin
      start <= 1'b0;
      in_value <= word_t'($urandom);
    end
  end

  always @(posedge clk) begin
    flags_t want;
    flags_t got;
    word_taken = rst_n && start && !busy;
    if (word_taken) begin
      expected_flags.push_back(classify_word(in_value));
      void'(pending_words.pop_front());
    end
    if (rst_n && out_valid) begin
      got = '{out_is_even, out_is_odd, out_is_prime};
      if (expected_flags.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result word: even=%b odd=%b prime=%b",
                   got.is_even, got.is_odd, got.is_prime);
      end else begin
        want = expected_flags.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected even=%b odd=%b prime=%b, got even=%b odd=%b prime=%b",
                     want.is_even, want.is_odd, want.is_prime,
                     got.is_even, got.is_odd, got.is_prime);
        end
      end
    end
  end

  initial begin
    word_t directed[$];
    directed = '{0, 1, 2, 3, 4, 5, 9, 15, 25, 49, 97, 121, 257, 32749, 32768,
                 16'h5555, 16'hAAAA, 63001, 65025, 65521, 65534, 65535};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) pending_words.push_back(directed[i]);
    repeat (26) pending_words.push_back(random_word());
    while (pending_words.size() != 0 || expected_flags.size() != 0) @(negedge clk);

    sender_idle_pct = 47;
    repeat (26) pending_words.push_back(random_word());
    while (pending_words.size() != 0 || expected_flags.size() != 0) @(negedge clk);

    sender_idle_pct = 0;
    repeat (26) pending_words.push_back(random_word());
    while (pending_words.size() != 0 || expected_flags.size() != 0) @(negedge clk);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_flags.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
